### rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the cascading prescaled timer bank.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_RELOAD = 2'd1,
    OP_CTRL   = 2'd2,
    OP_NOP    = 2'd3
  } cpt_op_t;

  // Shared prescale counter
  localparam int unsigned PRESCALE_W = 10;

  // Fixed width of the count result fields and of the reload input field
  localparam int unsigned FIELD_W    = 16;
  // Timers visible in the result beat
  localparam int unsigned OUT_TIMERS = 4;

  // Low-bit masks for div1 / div64 / div256 / div1024, indexed by prescale select
  localparam logic [PRESCALE_W-1:0] DIV_MASK [4] = '{
    10'h000, 10'h03F, 10'h0FF, 10'h3FF
  };

  // Per-beat command broadcast to every timer cell
  typedef struct packed {
    logic       tick;       // accepted tick beat
    logic       wr_reload;  // accepted reload write
    logic       wr_ctrl;    // accepted control write
    logic       enable;
    logic [1:0] psel;
    logic       cascade;
    logic       irq_en;
  } cpt_cmd_t;

endpackage

### rtl/cpt_prescaler.sv
// ----------------------------------------------------------------------------
// cpt_prescaler
// Shared 10-bit prescale counter; flags which divisions hit on this tick.
// ----------------------------------------------------------------------------
module cpt_prescaler (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick,
  output logic [3:0] div_hit
);
  import cpt_pkg::*;

  logic [PRESCALE_W-1:0] pre_cnt_r;
  logic [PRESCALE_W-1:0] pre_cnt_nxt;

  // wraps 1023 -> 0 naturally
  assign pre_cnt_nxt = pre_cnt_r + PRESCALE_W'(1);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      div_hit[k] = ~|(pre_cnt_nxt & DIV_MASK[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r <= '0;
    end else if (tick) begin
      pre_cnt_r <= pre_cnt_nxt;
    end
  end

endmodule

### rtl/cpt_timer_cell.sv
// ----------------------------------------------------------------------------
// cpt_timer_cell
// One timer of the bank: counter, reload and control; takes the overflow of
// the cell below and passes its own overflow to the cell above.
// ----------------------------------------------------------------------------
module cpt_timer_cell #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter bit          CAN_CASCADE = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cpt_pkg::cpt_cmd_t      cmd,
  input  logic                   sel,
  input  logic [COUNT_WIDTH-1:0] reload_in,
  input  logic [3:0]             div_hit,
  input  logic                   ovf_in,
  output logic                   ovf_out,
  output logic                   irq,
  output logic [COUNT_WIDTH-1:0] count_nxt
);
  import cpt_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] reload_r;
  logic [1:0]             psel_r;
  logic                   casc_r;
  logic                   irqen_r;
  logic                   en_r;
  logic                   advance;
  logic                   wrap;
  logic                   start;

  assign advance = cmd.tick && en_r &&
                   ((CAN_CASCADE && casc_r) ? ovf_in : div_hit[psel_r]);
  assign wrap    = &cnt_r;
  assign ovf_out = advance && wrap;
  assign irq     = ovf_out && irqen_r;
  // rising edge of enable
  assign start   = sel && cmd.wr_ctrl && cmd.enable && !en_r;

  always_comb begin
    count_nxt = cnt_r;
    if (advance) begin
      count_nxt = wrap ? reload_r : cnt_r + COUNT_WIDTH'(1);
    end else if (start) begin
      count_nxt = reload_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      reload_r <= '0;
      psel_r   <= '0;
      casc_r   <= 1'b0;
      irqen_r  <= 1'b0;
      en_r     <= 1'b0;
    end else begin
      cnt_r <= count_nxt;
      if (sel && cmd.wr_reload) begin
        reload_r <= reload_in;
      end
      if (sel && cmd.wr_ctrl) begin
        psel_r  <= cmd.psel;
        casc_r  <= cmd.cascade;
        irqen_r <= cmd.irq_en;
        en_r    <= cmd.enable;
      end
    end
  end

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == $past(reload_r))
    else $error("counter not loaded on enable");

  a_ovf_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_out |=> cnt_r == $past(reload_r))
    else $error("counter not reloaded on overflow");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en_r && !start |=> $stable(cnt_r))
    else $error("stopped timer moved");

endmodule

### rtl/cascading_prescaled_timer_bank_core.sv
// ----------------------------------------------------------------------------
// cascading_prescaled_timer_bank_core
// Bank of up-counting timers sharing a 10-bit prescaler, with cascade from
// each timer to the one above it, reload on overflow and an interrupt mask.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                  | beat
//   --------+-----------+----------------------------------------+-------------
//   in      | input     | in_valid/in_stall, op, index, fields   | tick / write
//   out     | output    | out_valid/out_stall, count0..3, irq    | one per in
//
// One in beat per clock while in_stall is low. Tick and write beats complete
// in the cycle they are accepted; the cascade overflow ripples through the
// timer cells that same cycle; the result is in the output register next cycle.
// Reset (rst_n low, synchronous) stops all timers and clears every counter,
// reload value and the prescaler. in_stall is raised only while a result sits
// in the output register and out_stall holds it, so the input is never stalled
// while the output side drains.
// ----------------------------------------------------------------------------
module cascading_prescaled_timer_bank_core #(
  parameter int unsigned NUM_TIMERS  = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [1:0]                    in_timer_index,
  input  logic [cpt_pkg::FIELD_W-1:0]   in_reload_value,
  input  logic                          in_enable_bit,
  input  logic [1:0]                    in_prescale_select,
  input  logic                          in_cascade_bit,
  input  logic                          in_irq_enable_bit,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpt_pkg::FIELD_W-1:0]   out_count0,
  output logic [cpt_pkg::FIELD_W-1:0]   out_count1,
  output logic [cpt_pkg::FIELD_W-1:0]   out_count2,
  output logic [cpt_pkg::FIELD_W-1:0]   out_count3,
  output logic [cpt_pkg::OUT_TIMERS-1:0] out_irq_mask
);
  import cpt_pkg::*;

  // wide enough for both the count and the fixed field width
  localparam int unsigned EXT_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

  logic                   accept;
  cpt_op_t                op;
  cpt_cmd_t               cmd;
  logic [3:0]             div_hit;
  logic [EXT_W-1:0]       reload_ext;
  logic [COUNT_WIDTH-1:0] reload_cw;

  logic [NUM_TIMERS:0]    ovf_chain;   // ovf_chain[i] feeds cell i
  logic [NUM_TIMERS-1:0]  sel;
  logic [NUM_TIMERS-1:0]  irq_vec;
  logic [COUNT_WIDTH-1:0] count_nxt [NUM_TIMERS];

  logic [FIELD_W-1:0]     res_count [OUT_TIMERS];
  logic [OUT_TIMERS-1:0]  res_irq;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [FIELD_W-1:0]     count_r [OUT_TIMERS];
  logic [OUT_TIMERS-1:0]  irq_mask_r;

  // --------------------------------------------------------------------------
  // Handshake: a single output register; take a new beat whenever it is empty
  // or being drained this cycle.
  // --------------------------------------------------------------------------
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op       = cpt_op_t'(in_op);

  always_comb begin
    cmd           = '0;
    cmd.tick      = accept && (op == OP_TICK);
    cmd.wr_reload = accept && (op == OP_RELOAD);
    cmd.wr_ctrl   = accept && (op == OP_CTRL);
    cmd.enable    = in_enable_bit;
    cmd.psel      = in_prescale_select;
    cmd.cascade   = in_cascade_bit;
    cmd.irq_en    = in_irq_enable_bit;
  end

  // reload field resized to the counter width
  assign reload_ext = EXT_W'(in_reload_value);
  assign reload_cw  = reload_ext[COUNT_WIDTH-1:0];

  cpt_prescaler u_prescaler (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (cmd.tick),
    .div_hit (div_hit)
  );

  // --------------------------------------------------------------------------
  // Row of timer cells. Timer 0 has no cell below, so it never cascades.
  // --------------------------------------------------------------------------
  assign ovf_chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    // index beyond the bank never matches, so such writes are dropped
    assign sel[i] = (32'(in_timer_index) == i);

    cpt_timer_cell #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .CAN_CASCADE (i != 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel[i]),
      .reload_in (reload_cw),
      .div_hit   (div_hit),
      .ovf_in    (ovf_chain[i]),
      .ovf_out   (ovf_chain[i+1]),
      .irq       (irq_vec[i]),
      .count_nxt (count_nxt[i])
    );
  end

  // --------------------------------------------------------------------------
  // Result fields: timers 0..3 only; missing timers read as zero.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < OUT_TIMERS; j++) begin : g_res
    if (j < NUM_TIMERS) begin : g_have
      logic [EXT_W-1:0] cnt_ext;
      assign cnt_ext      = EXT_W'(count_nxt[j]);
      assign res_count[j] = cnt_ext[FIELD_W-1:0];
      assign res_irq[j]   = irq_vec[j];
    end else begin : g_none
      assign res_count[j] = '0;
      assign res_irq[j]   = 1'b0;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_r    <= res_count;
      irq_mask_r <= res_irq;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_count0   = count_r[0];
  assign out_count1   = count_r[1];
  assign out_count2   = count_r[2];
  assign out_count3   = count_r[3];
  assign out_irq_mask = irq_mask_r;

  a_write_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op != OP_TICK) |=> out_irq_mask == '0)
    else $error("interrupt flagged on a non-tick beat");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !accept |=> !out_valid)
    else $error("result repeated after handoff");

endmodule

### verif/timer_bank_checker.sv
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches both channels of the timer bank, tracks the timers itself and
// compares every result beat with the expected counters and interrupt mask.
// ----------------------------------------------------------------------------
module timer_bank_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [1:0]                     in_timer_index,
  input  logic [cpt_pkg::FIELD_W-1:0]    in_reload_value,
  input  logic                           in_enable_bit,
  input  logic [1:0]                     in_prescale_select,
  input  logic                           in_cascade_bit,
  input  logic                           in_irq_enable_bit,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [cpt_pkg::FIELD_W-1:0]    out_count0,
  input  logic [cpt_pkg::FIELD_W-1:0]    out_count1,
  input  logic [cpt_pkg::FIELD_W-1:0]    out_count2,
  input  logic [cpt_pkg::FIELD_W-1:0]    out_count3,
  input  logic [cpt_pkg::OUT_TIMERS-1:0] out_irq_mask,
  output int unsigned                    fail_count,
  output int unsigned                    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  // low prescaler bits that must be zero for div1 / div64 / div256 / div1024
  localparam logic [PRESCALE_W-1:0] PRESCALE_LOW_BITS [4] = '{
    10'h000, 10'h03F, 10'h0FF, 10'h3FF
  };

  typedef struct packed {
    logic [OUT_TIMERS-1:0][FIELD_W-1:0] count;
    logic [OUT_TIMERS-1:0]              irq_mask;
  } bank_view_t;

  logic [FIELD_W-1:0]    tmr_count   [OUT_TIMERS];
  logic [FIELD_W-1:0]    tmr_reload  [OUT_TIMERS];
  logic [1:0]            tmr_psel    [OUT_TIMERS];
  logic                  tmr_cascade [OUT_TIMERS];
  logic                  tmr_irq_en  [OUT_TIMERS];
  logic                  tmr_run     [OUT_TIMERS];
  logic [PRESCALE_W-1:0] prescaler;

  bank_view_t  expected_views [$];
  int unsigned mismatches = 0;

  // Applies one input beat to the tracked timers and returns the result beat.
  function automatic bank_view_t step_timer_bank(
    input cpt_op_t            op,
    input logic [1:0]         idx,
    input logic [FIELD_W-1:0] rv,
    input logic               en,
    input logic [1:0]         ps,
    input logic               casc,
    input logic               ie
  );
    bank_view_t         view;
    logic               carry;
    logic               step;
    logic               wrap;
    logic [FIELD_W-1:0] nxt;
    view  = '0;
    carry = 1'b0;
    case (op)
      OP_TICK: begin
        prescaler = prescaler + 1'b1;
        for (int t = 0; t < OUT_TIMERS; t++) begin
          step = 1'b0;
          wrap = 1'b0;
          if (tmr_run[t]) begin
            // timer 0 has nothing below it and always uses the prescaler
            if (t != 0 && tmr_cascade[t]) begin
              step = carry;
            end else begin
              step = (prescaler & PRESCALE_LOW_BITS[tmr_psel[t]]) == '0;
            end
          end
          if (step) begin
            nxt = tmr_count[t] + 1'b1;
            if (nxt == '0) begin
              wrap = 1'b1;
              nxt  = tmr_reload[t];
              if (tmr_irq_en[t]) begin
                view.irq_mask[t] = 1'b1;
              end
            end
            tmr_count[t] = nxt;
          end
          carry = wrap;
        end
      end
      OP_RELOAD: begin
        tmr_reload[idx] = rv;
      end
      OP_CTRL: begin
        // counter loads only on a rising edge of enable
        if (en && !tmr_run[idx]) begin
          tmr_count[idx] = tmr_reload[idx];
        end
        tmr_psel[idx]    = ps;
        tmr_cascade[idx] = casc;
        tmr_irq_en[idx]  = ie;
        tmr_run[idx]     = en;
      end
      default: begin
      end
    endcase
    for (int t = 0; t < OUT_TIMERS; t++) begin
      view.count[t] = tmr_count[t];
    end
    return view;
  endfunction

  always @(posedge clk) begin
    bank_view_t got;
    bank_view_t want;
    if (!rst_n) begin
      for (int t = 0; t < OUT_TIMERS; t++) begin
        tmr_count[t]   = '0;
        tmr_reload[t]  = '0;
        tmr_psel[t]    = '0;
        tmr_cascade[t] = 1'b0;
        tmr_irq_en[t]  = 1'b0;
        tmr_run[t]     = 1'b0;
      end
      prescaler = '0;
      expected_views.delete();
    end else begin
      // results are registered, so a result beat never belongs to the input
      // beat accepted at the same edge: check first, then predict
      if (out_valid && !out_stall) begin
        got.count[0] = out_count0;
        got.count[1] = out_count1;
        got.count[2] = out_count2;
        got.count[3] = out_count3;
        got.irq_mask = out_irq_mask;
        if (expected_views.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          for (int k = 0; k < OUT_TIMERS; k++) begin
            if (got.count[k] !== want.count[k]) begin
              $error("count%0d: expected %h, actual %h", k, want.count[k], got.count[k]);
              mismatches++;
            end
          end
          if (got.irq_mask !== want.irq_mask) begin
            $error("irq_mask: expected %b, actual %b", want.irq_mask, got.irq_mask);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_views.push_back(step_timer_bank(cpt_op_t'(in_op), in_timer_index,
                                                 in_reload_value, in_enable_bit,
                                                 in_prescale_select, in_cascade_bit,
                                                 in_irq_enable_bit));
      end
    end
    fail_count <= mismatches;
    awaiting   <= expected_views.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the timer bank with tick, reload and control beats: a directed
// opening that walks the cascade chain and the reload/enable corner cases,
// then random traffic biased toward fast overflows. The checker instance
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  // prescale select codes
  localparam logic [1:0] PSEL_DIV1    = 2'd0;
  localparam logic [1:0] PSEL_DIV64   = 2'd1;
  localparam logic [1:0] PSEL_DIV256  = 2'd2;
  localparam logic [1:0] PSEL_DIV1024 = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1600;
  // longest correct stretch without a beat is the long receiver hold
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                  clk                = 1'b0;
  logic                  rst_n              = 1'b0;
  logic                  in_valid           = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op              = OP_NOP;
  logic [1:0]            in_timer_index     = '0;
  logic [FIELD_W-1:0]    in_reload_value    = '0;
  logic                  in_enable_bit      = 1'b0;
  logic [1:0]            in_prescale_select = '0;
  logic                  in_cascade_bit     = 1'b0;
  logic                  in_irq_enable_bit  = 1'b0;
  logic                  out_valid;
  logic                  out_stall          = 1'b0;
  logic [FIELD_W-1:0]    out_count0;
  logic [FIELD_W-1:0]    out_count1;
  logic [FIELD_W-1:0]    out_count2;
  logic [FIELD_W-1:0]    out_count3;
  logic [OUT_TIMERS-1:0] out_irq_mask;

  int unsigned fail_count;
  int unsigned awaiting;
  int unsigned burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cascading_prescaled_timer_bank_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_timer_index     (in_timer_index),
    .in_reload_value    (in_reload_value),
    .in_enable_bit      (in_enable_bit),
    .in_prescale_select (in_prescale_select),
    .in_cascade_bit     (in_cascade_bit),
    .in_irq_enable_bit  (in_irq_enable_bit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_count0         (out_count0),
    .out_count1         (out_count1),
    .out_count2         (out_count2),
    .out_count3         (out_count3),
    .out_irq_mask       (out_irq_mask)
  );

  timer_bank_checker u_timer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_timer_index     (in_timer_index),
    .in_reload_value    (in_reload_value),
    .in_enable_bit      (in_enable_bit),
    .in_prescale_select (in_prescale_select),
    .in_cascade_bit     (in_cascade_bit),
    .in_irq_enable_bit  (in_irq_enable_bit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_count0         (out_count0),
    .out_count1         (out_count1),
    .out_count2         (out_count2),
    .out_count3         (out_count3),
    .out_irq_mask       (out_irq_mask),
    .fail_count         (fail_count),
    .awaiting           (awaiting)
  );

  // Offers one beat and returns at the edge that accepts it. Valid stays high
  // across a burst; at the end of a burst it may drop for a random gap. The next
  // call raises it again at a later edge, so valid never gets two updates in
  // one time step.
  task automatic offer(
    input cpt_op_t            op,
    input logic [1:0]         idx,
    input logic [FIELD_W-1:0] rv,
    input logic               en,
    input logic [1:0]         ps,
    input logic               casc,
    input logic               ie
  );
    int unsigned gap;
    in_valid           <= 1'b1;
    in_op              <= op;
    in_timer_index     <= idx;
    in_reload_value    <= rv;
    in_enable_bit      <= en;
    in_prescale_select <= ps;
    in_cascade_bit     <= casc;
    in_irq_enable_bit  <= ie;
    // in_stall read right after the edge is the value the block sampled
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // tick beat; the write fields are don't-care for ticks, so they get noise
  task automatic tick_beat();
    offer(OP_TICK, 2'($urandom), 16'($urandom), 1'($urandom), 2'($urandom),
          1'($urandom), 1'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned        items_sent;
    int unsigned        pick;
    logic [FIELD_W-1:0] rv;
    logic [1:0]         ps;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // all timers stopped: ticks move only the hidden prescaler
    tick_beat();
    tick_beat();
    // unused opcode changes nothing
    offer(OP_NOP, 2'd3, 16'hFFFF, 1'b1, PSEL_DIV1024, 1'b1, 1'b1);

    // reload values at the top of the range so the chain overflows quickly
    offer(OP_RELOAD, 2'd0, 16'hFFFF, 1'b0, PSEL_DIV1, 1'b0, 1'b0);
    offer(OP_RELOAD, 2'd1, 16'hFFFE, 1'b0, PSEL_DIV1, 1'b0, 1'b0);
    offer(OP_RELOAD, 2'd2, 16'hFFFF, 1'b0, PSEL_DIV1, 1'b0, 1'b0);
    offer(OP_RELOAD, 2'd3, 16'hFFFF, 1'b0, PSEL_DIV1, 1'b0, 1'b0);

    // timer 0 with cascade set must still run off the prescaler
    offer(OP_CTRL, 2'd0, 16'h0000, 1'b1, PSEL_DIV1, 1'b1, 1'b1);
    // timer 1 cascades; its div1024 select must be ignored; no interrupt
    offer(OP_CTRL, 2'd1, 16'h0000, 1'b1, PSEL_DIV1024, 1'b1, 1'b0);
    offer(OP_CTRL, 2'd2, 16'h0000, 1'b1, PSEL_DIV1, 1'b1, 1'b1);
    offer(OP_CTRL, 2'd3, 16'h0000, 1'b1, PSEL_DIV256, 1'b1, 1'b1);
    // ripple through all four timers
    repeat (6) tick_beat();

    // reload write leaves the running counter alone; zero reload next wrap
    offer(OP_RELOAD, 2'd1, 16'h0000, 1'b1, PSEL_DIV64, 1'b1, 1'b1);
    repeat (2) tick_beat();

    // enable again while already running: no reload of the counter
    offer(OP_CTRL, 2'd0, 16'h1234, 1'b1, PSEL_DIV1, 1'b0, 1'b1);
    // stop then restart timer 2: restart loads from reload
    offer(OP_CTRL, 2'd2, 16'h0000, 1'b0, PSEL_DIV1, 1'b1, 1'b1);
    offer(OP_CTRL, 2'd2, 16'h0000, 1'b1, PSEL_DIV1, 1'b1, 1'b1);
    // timer 0 onto div64
    offer(OP_CTRL, 2'd0, 16'hFFFF, 1'b1, PSEL_DIV64, 1'b0, 1'b0);
    repeat (2) tick_beat();
    offer(OP_NOP, 2'd0, 16'h0000, 1'b0, PSEL_DIV1, 1'b0, 1'b0);

    // ---- random part ----
    // mostly ticks; reloads lean toward values just below all-ones so the
    // cascade chain wraps often, with full-range and extreme values mixed in
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        tick_beat();
        items_sent++;
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0, 1:    rv = 16'hFFF0 | 16'($urandom_range(0, 15));
          2:       rv = 16'($urandom);
          default: rv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        offer(OP_RELOAD, 2'($urandom), rv, 1'($urandom), 2'($urandom),
              1'($urandom), 1'($urandom));
        items_sent++;
      end else if (pick < 97) begin
        // favor div1 so prescaled timers actually move within the run
        ps = $urandom_range(0, 1) ? PSEL_DIV1 : 2'($urandom);
        offer(OP_CTRL, 2'($urandom), 16'($urandom), $urandom_range(0, 9) < 7, ps,
              1'($urandom), $urandom_range(0, 9) < 6);
        items_sent++;
      end else begin
        offer(OP_NOP, 2'($urandom), 16'($urandom), 1'($urandom), 2'($urandom),
              1'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    // the pending count is a registered copy in the checker; drain it, then wait
    // for anything stray from the output register
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: a random stall pattern, one long hold early in the random part
  // so the output register fills and the input backs up, then random modes.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned len;
    wait (rst_n);
    @(posedge clk);
    repeat (150) begin
      out_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
    out_stall <= 1'b1;
    repeat ($urandom_range(200, 300)) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 7);
      len  = $urandom_range(10, 120);
      repeat (len) begin
        case (mode)
          0, 1:    out_stall <= 1'b0;
          2, 3, 4: out_stall <= ($urandom_range(0, 3) == 0);
          5:       out_stall <= 1'($urandom_range(0, 1));
          6:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (len > 60) ? ($urandom_range(0, 3) == 0) : 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat on either channel.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

### filelist.f
rtl/cpt_pkg.sv
rtl/cpt_prescaler.sv
rtl/cpt_timer_cell.sv
rtl/cascading_prescaled_timer_bank_core.sv
verif/timer_bank_checker.sv
verif/tb_top.sv
